// File: rtl/aph_pkg.sv
// Shared types and fixed constants of the allpass-pair Hilbert transformer.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package aph_pkg;

  // Coefficient format: signed Q1.15, fixed by the register layout.
  localparam int COEF_W     = 16;
  localparam int COEF_FRAC  = 15;
  // Integer guard bits of the section state above the sample format.
  localparam int GUARD_BITS = 4;
  // Width of one packed coefficient-pair register.
  localparam int REG_W      = 32;

  // Request command codes.
  localparam logic CMD_PROCESS = 1'b0;
  localparam logic CMD_CLEAR   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // take the new sample into both chain accumulators
    logic clear;     // zero all section state
    logic mul_en;    // run the multiply stage for the current step
    logic out_load;  // move the finished chain outputs into the output register
  } aph_cmd_t;

endpackage

`default_nettype wire

// File: rtl/aph_regs.sv
// APB-style register file holding the packed coefficient pairs.
// Depends on aph_pkg for the register and coefficient widths.
`default_nettype none

module aph_regs #(
  parameter int SECTIONS_PER_CHAIN = 6,
  parameter int AW = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [AW-1:0]                 paddr,
  input  wire logic [aph_pkg::REG_W-1:0]     pwdata,
  output logic      [aph_pkg::REG_W-1:0]     prdata,
  output logic                               pready,
  output logic signed [aph_pkg::COEF_W-1:0]  coef_a [SECTIONS_PER_CHAIN],
  output logic signed [aph_pkg::COEF_W-1:0]  coef_b [SECTIONS_PER_CHAIN]
);

  localparam int IW = AW - 2;

  logic [aph_pkg::REG_W-1:0] coef_r [SECTIONS_PER_CHAIN];
  logic [IW-1:0]             idx;
  logic                      idx_ok;
  logic                      wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[AW-1:2];
  assign idx_ok = (int'(idx) < SECTIONS_PER_CHAIN);
  assign wr_en  = psel && penable && pwrite && idx_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SECTIONS_PER_CHAIN; i++) begin
        coef_r[i] <= '0;
      end
    end else if (wr_en) begin
      coef_r[idx] <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (idx_ok) begin
      prdata = coef_r[idx];
    end
  end

  // Split each pair: high half feeds chain A, low half chain B.
  always_comb begin
    for (int i = 0; i < SECTIONS_PER_CHAIN; i++) begin
      coef_a[i] = coef_r[i][aph_pkg::REG_W-1:aph_pkg::COEF_W];
      coef_b[i] = coef_r[i][aph_pkg::COEF_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/aph_dp.sv
// Datapath: section state, one shared two-stage multiply-add and the output register.
// Depends on aph_pkg for the command struct and fixed formats.
`default_nettype none

module aph_dp #(
  parameter int SECTIONS_PER_CHAIN = 6,
  parameter int SAMPLE_WIDTH = 16,
  parameter int KW = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire aph_pkg::aph_cmd_t                  cmd,
  input  wire logic [KW-1:0]                      step,
  input  wire logic signed [SAMPLE_WIDTH-1:0]     sample,
  input  wire logic                               block_last,
  input  wire logic signed [aph_pkg::COEF_W-1:0]  coef_a [SECTIONS_PER_CHAIN],
  input  wire logic signed [aph_pkg::COEF_W-1:0]  coef_b [SECTIONS_PER_CHAIN],
  output logic signed [SAMPLE_WIDTH-1:0]          phase_a,
  output logic signed [SAMPLE_WIDTH-1:0]          phase_b,
  output logic                                    block_last_out
);

  localparam int NE   = 2 * SECTIONS_PER_CHAIN;
  localparam int SW   = SAMPLE_WIDTH + aph_pkg::GUARD_BITS;
  localparam int DW   = SW + 1;
  localparam int PW   = DW + aph_pkg::COEF_W;
  localparam int RW   = PW - aph_pkg::COEF_FRAC;
  localparam int SUMW = RW + 1;
  localparam int TW   = aph_pkg::GUARD_BITS + 1;
  localparam logic signed [PW-1:0] RND_HALF = PW'(2 ** (aph_pkg::COEF_FRAC - 1));

  // Section state, entry k serves step k: even steps chain B, odd steps chain A.
  logic signed [SW-1:0] di_r [NE];
  logic signed [SW-1:0] do_r [NE];

  logic signed [SW-1:0] xa_r, xb_r;
  logic                 last_r;

  // Multiply stage register.
  logic signed [PW-1:0] p_r;
  logic signed [SW-1:0] xprev_r;
  logic [KW-1:0]        acc_idx_r;
  logic                 acc_vld_r;

  logic signed [SAMPLE_WIDTH-1:0] phase_a_r, phase_b_r;
  logic                           last_out_r;

  logic signed [aph_pkg::COEF_W-1:0] coef;
  logic signed [SW-1:0]   x_sel;
  logic signed [DW-1:0]   diff;
  logic signed [PW-1:0]   prod;
  logic signed [PW-1:0]   rnd;
  logic signed [SUMW-1:0] sum;
  logic [SUMW-SW:0]       sum_top;
  logic signed [SW-1:0]   y;
  logic [TW-1:0]          top_a, top_b;
  logic signed [SAMPLE_WIDTH-1:0] sat_a, sat_b;

  // Stage 1: difference and product.
  always_comb begin
    coef  = step[0] ? coef_a[step[KW-1:1]] : coef_b[step[KW-1:1]];
    x_sel = step[0] ? xa_r : xb_r;
    diff  = DW'(x_sel) - DW'(do_r[step]);
    prod  = PW'(coef) * PW'(diff);
  end

  // Stage 2: round half up, add delayed input, saturate to the state width.
  always_comb begin
    rnd     = p_r + RND_HALF;
    sum     = SUMW'($signed(rnd[PW-1:aph_pkg::COEF_FRAC])) + SUMW'(xprev_r);
    sum_top = sum[SUMW-1:SW-1];
    if ((&sum_top) || !(|sum_top)) begin
      y = sum[SW-1:0];
    end else if (sum[SUMW-1]) begin
      y = {1'b1, {(SW-1){1'b0}}};
    end else begin
      y = {1'b0, {(SW-1){1'b1}}};
    end
  end

  // Output saturation from the state width to the sample width.
  always_comb begin
    top_a = xa_r[SW-1:SAMPLE_WIDTH-1];
    top_b = xb_r[SW-1:SAMPLE_WIDTH-1];
    if ((&top_a) || !(|top_a)) begin
      sat_a = xa_r[SAMPLE_WIDTH-1:0];
    end else begin
      sat_a = xa_r[SW-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                         : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
    if ((&top_b) || !(|top_b)) begin
      sat_b = xb_r[SAMPLE_WIDTH-1:0];
    end else begin
      sat_b = xb_r[SW-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                         : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < NE; i++) begin
        di_r[i] <= '0;
        do_r[i] <= '0;
      end
    end else begin
      if (cmd.mul_en) begin
        di_r[step] <= x_sel;
      end
      if (acc_vld_r) begin
        do_r[acc_idx_r] <= y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= 1'b0;
    end else begin
      acc_vld_r <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p_r       <= prod;
      xprev_r   <= di_r[step];
      acc_idx_r <= step;
    end
    if (cmd.load) begin
      xa_r   <= SW'(sample);
      xb_r   <= SW'(sample);
      last_r <= block_last;
    end else if (acc_vld_r) begin
      if (acc_idx_r[0]) begin
        xa_r <= y;
      end else begin
        xb_r <= y;
      end
    end
    if (cmd.out_load) begin
      phase_a_r  <= sat_a;
      phase_b_r  <= sat_b;
      last_out_r <= last_r;
    end
  end

  assign phase_a        = phase_a_r;
  assign phase_b        = phase_b_r;
  assign block_last_out = last_out_r;

endmodule

`default_nettype wire

// File: rtl/aph_ctrl.sv
// Controller: request handshake, step sequencing and result valid.
// Depends on aph_pkg for the command struct and command codes.
`default_nettype none

module aph_ctrl #(
  parameter int SECTIONS_PER_CHAIN = 6,
  parameter int KW = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_command,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output aph_pkg::aph_cmd_t   cmd,
  output logic [KW-1:0]       step
);

  localparam logic [KW-1:0] LAST_STEP = KW'(2 * SECTIONS_PER_CHAIN - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_OUT
  } state_t;

  state_t        state_r, state_nxt;
  logic [KW-1:0] step_r, step_nxt;
  logic          out_valid_r, out_valid_nxt;

  always_comb begin
    in_ready     = (state_r == S_IDLE);
    cmd.load     = in_ready && in_valid && (in_command == aph_pkg::CMD_PROCESS);
    cmd.clear    = in_ready && in_valid && (in_command == aph_pkg::CMD_CLEAR);
    cmd.mul_en   = (state_r == S_RUN);
    cmd.out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (step_r == LAST_STEP) begin
          state_nxt = S_DRAIN;
        end else begin
          step_nxt = step_r + KW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (cmd.out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign step      = step_r;

  a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_RUN) && (step_r == '0))
    else $error("process request did not start the step sequence at step zero");

  a_run_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) && (step_r == LAST_STEP) |=> (state_r == S_DRAIN))
    else $error("last step not followed by the drain cycle");

  a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != '0) |-> (state_r == S_RUN))
    else $error("step counter moved outside the run state");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result raised without a finished sample");

endmodule

`default_nettype wire

// File: rtl/allpass_pair_hilbert_transformer.sv
// Top level of the allpass-pair Hilbert transformer: registers, controller and datapath.
// Depends on aph_pkg, aph_regs, aph_ctrl and aph_dp.
//
// Each processed sample runs through two chains of SECTIONS_PER_CHAIN first-order
// allpass sections, y = c*(x - y_prev) + x_prev, and leaves as phase_a (chain A, high
// coefficient halves) and phase_b (chain B, low halves), roughly 90 degrees apart.
// A single multiplier serves all 2*SECTIONS_PER_CHAIN section evaluations: stage one
// forms the difference and product, stage two rounds half up, adds the delayed input
// and saturates to the Q5.15 state. Chains B and A alternate through the two stages;
// a process request is accepted, then every section step runs through the shared
// multiply-add, the pipeline drains and the output register is loaded, after which
// the block is ready again. A finished result waits in the output register while the
// next request is already being worked on; the final load stalls only if that
// register is still occupied. A clear request zeroes every section's delayed input
// and output at once and gives no result. Coefficient pairs sit at byte address 4*k
// for section k; write them only while the block is idle.
`default_nettype none

module allpass_pair_hilbert_transformer #(
  parameter int SECTIONS_PER_CHAIN = 6,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_command,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  input  wire logic                          in_block_last_in,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]     out_phase_a,
  output logic signed [SAMPLE_WIDTH-1:0]     out_phase_b,
  output logic                               out_block_last_out,
  // coefficient register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [$clog2(4*SECTIONS_PER_CHAIN)-1:0] paddr,
  input  wire logic [aph_pkg::REG_W-1:0]     pwdata,
  output logic      [aph_pkg::REG_W-1:0]     prdata,
  output logic                               pready
);

  // Step counter covers both chains; its low bit picks the chain.
  localparam int KW = $clog2(2 * SECTIONS_PER_CHAIN);
  localparam int AW = $clog2(4 * SECTIONS_PER_CHAIN);

  logic signed [aph_pkg::COEF_W-1:0] coef_a [SECTIONS_PER_CHAIN];
  logic signed [aph_pkg::COEF_W-1:0] coef_b [SECTIONS_PER_CHAIN];
  aph_pkg::aph_cmd_t                 cmd;
  logic [KW-1:0]                     step;

  aph_regs #(
    .SECTIONS_PER_CHAIN (SECTIONS_PER_CHAIN),
    .AW                 (AW)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_a  (coef_a),
    .coef_b  (coef_b)
  );

  // Sequence the steps and own the handshakes.
  aph_ctrl #(
    .SECTIONS_PER_CHAIN (SECTIONS_PER_CHAIN),
    .KW                 (KW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .step       (step)
  );

  // Hold section state, run the shared multiply-add, hold the result.
  aph_dp #(
    .SECTIONS_PER_CHAIN (SECTIONS_PER_CHAIN),
    .SAMPLE_WIDTH       (SAMPLE_WIDTH),
    .KW                 (KW)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .step           (step),
    .sample         (in_sample_in),
    .block_last     (in_block_last_in),
    .coef_a         (coef_a),
    .coef_b         (coef_b),
    .phase_a        (out_phase_a),
    .phase_b        (out_phase_b),
    .block_last_out (out_block_last_out)
  );

endmodule

`default_nettype wire
